/* sv/bb3_pkg.sv */
// Shared types, constants and helper functions for the 3x3 RGB box blur core.
// No dependencies; every other file refers to it by scoped names.

package bb3_pkg;

  // Frame geometry. MAX_WIDTH must be a power of two so that an address
  // is simply {row, col}.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int SIZE_W     = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;

  // Pixel channels
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // Window sums: up to nine channel values
  localparam int SUM_W = $clog2(9 * ((1 << CH_W) - 1) + 1);
  localparam int CNT_W = 4;

  // Reciprocal scaling for the divide by the window pixel count
  localparam int RECIP_SH = 16;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // Configuration port
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET   = 9'd256;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Payloads
  typedef struct packed {
    logic             operation;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic setup;   // build the clamped window from the latched position
    logic gather;  // issue one frame store read
    logic divide;  // scale the sums by the reciprocal of the count
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_read;  // current gather address is the window's last pixel
  } dp_status_t;

  // ceil(2^16 / n) for the counts a clamped 3x3 window can have.
  // Exact floor division for every sum below 2^15.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/bb3_ctrl.sv */
// Sequencer for the box blur core: accepts commands and steps the datapath
// through window setup, gather, divide and result. Uses bb3_pkg.

module bb3_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                op_i,
  input  bb3_pkg::dp_status_t status_i,
  output bb3_pkg::dp_cmd_t    cmd_o,
  output logic                busy,
  output logic                done_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_GATHER = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  // Next state; a write finishes in its accept cycle
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op_i == bb3_pkg::OP_READ)) state_d = ST_SETUP;
      end
      ST_SETUP:  state_d = ST_GATHER;
      ST_GATHER: begin
        if (status_i.last_read) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_DIVIDE;
      ST_DIVIDE: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands and status
  always_comb begin
    cmd_o.accept = accept;
    cmd_o.setup  = (state_q == ST_SETUP);
    cmd_o.gather = (state_q == ST_GATHER);
    cmd_o.divide = (state_q == ST_DIVIDE);
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

/* sv/bb3_datapath.sv */
// Datapath of the box blur core: size registers, frame store, window
// address counters, channel accumulators and reciprocal divide. Uses bb3_pkg.

module bb3_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bb3_pkg::CFG_W-1:0]          cfg_data_i,
  input  bb3_pkg::in_item_t                  in_i,
  input  bb3_pkg::dp_cmd_t                   cmd_i,
  output bb3_pkg::dp_status_t                status_o,
  output bb3_pkg::out_item_t                 out_o
);

  localparam int ROW_W  = bb3_pkg::ROW_W;
  localparam int COL_W  = bb3_pkg::COL_W;
  localparam int SIZE_W = bb3_pkg::SIZE_W;
  localparam int SUM_W  = bb3_pkg::SUM_W;
  localparam int CNT_W  = bb3_pkg::CNT_W;
  localparam int CH_W   = bb3_pkg::CH_W;
  localparam int PROD_W = bb3_pkg::PROD_W;

  // Size register in use: zero reads as one, large values saturate
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [bb3_pkg::CFG_W-1:0] v,
                                                   input int max);
    logic [SIZE_W-1:0] s;
    if (v == '0) begin
      s = SIZE_W'(1);
    end else if (32'(v) > 32'(max)) begin
      s = SIZE_W'(max);
    end else begin
      s = SIZE_W'(v);
    end
    return s;
  endfunction

  logic [bb3_pkg::CFG_W-1:0] width_q, height_q;
  logic [SIZE_W-1:0]         w_eff, h_eff;
  logic [ROW_W-1:0]          h_last, pos_r_d, pos_r_q, r1_q, y_q;
  logic [COL_W-1:0]          w_last, pos_c_d, pos_c_q, c0_q, c1_q, x_q;
  logic                      wr_en;
  logic [bb3_pkg::PIX_W-1:0] mem_q [2**bb3_pkg::ADDR_W];
  logic [bb3_pkg::PIX_W-1:0] rd_data_q;
  logic                      rd_valid_q;
  logic [SUM_W-1:0]          sum_r_q, sum_g_q, sum_b_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [PROD_W-1:0]         prod_r_q, prod_g_q, prod_b_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::CFG_SIZE_RESET;
      height_q <= bb3_pkg::CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        bb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff  = clamp_size(width_q, bb3_pkg::MAX_WIDTH);
  assign h_eff  = clamp_size(height_q, bb3_pkg::MAX_HEIGHT);
  assign w_last = COL_W'(w_eff - SIZE_W'(1));
  assign h_last = ROW_W'(h_eff - SIZE_W'(1));

  // Write only inside the image; reads saturate the center to the last row/col
  assign wr_en = cmd_i.accept && (in_i.operation == bb3_pkg::OP_WRITE) &&
                 (SIZE_W'(in_i.row) < h_eff) && (SIZE_W'(in_i.col) < w_eff);
  assign pos_r_d = (SIZE_W'(in_i.row) >= h_eff) ? h_last : in_i.row;
  assign pos_c_d = (SIZE_W'(in_i.col) >= w_eff) ? w_last : in_i.col;

  // Window bounds and gather counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_r_q <= pos_r_d;
      pos_c_q <= pos_c_d;
    end
    if (cmd_i.setup) begin
      y_q  <= (pos_r_q == '0) ? '0 : pos_r_q - ROW_W'(1);
      x_q  <= (pos_c_q == '0) ? '0 : pos_c_q - COL_W'(1);
      c0_q <= (pos_c_q == '0) ? '0 : pos_c_q - COL_W'(1);
      r1_q <= ((SIZE_W'(pos_r_q) + SIZE_W'(1)) < h_eff) ? pos_r_q + ROW_W'(1) : h_last;
      c1_q <= ((SIZE_W'(pos_c_q) + SIZE_W'(1)) < w_eff) ? pos_c_q + COL_W'(1) : w_last;
    end else if (cmd_i.gather) begin
      if (x_q == c1_q) begin
        x_q <= c0_q;
        y_q <= y_q + ROW_W'(1);
      end else begin
        x_q <= x_q + COL_W'(1);
      end
    end
  end

  assign status_o.last_read = (x_q == c1_q) && (y_q == r1_q);

  // Frame store: one port, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[{in_i.row, in_i.col}] <= {in_i.red_in, in_i.green_in, in_i.blue_in};
    end
    if (cmd_i.gather) begin
      rd_data_q <= mem_q[{y_q, x_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.gather;
    end
  end

  // Channel accumulators and pixel count
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
      cnt_q   <= '0;
    end else if (rd_valid_q) begin
      sum_r_q <= sum_r_q + SUM_W'(rd_data_q[3*CH_W-1:2*CH_W]);
      sum_g_q <= sum_g_q + SUM_W'(rd_data_q[2*CH_W-1:CH_W]);
      sum_b_q <= sum_b_q + SUM_W'(rd_data_q[CH_W-1:0]);
      cnt_q   <= cnt_q + CNT_W'(1);
    end
  end

  // Floor divide by the count as a multiply by its scaled reciprocal
  always_ff @(posedge clk_i) begin
    if (cmd_i.divide) begin
      prod_r_q <= PROD_W'(sum_r_q) * PROD_W'(bb3_pkg::recip(cnt_q));
      prod_g_q <= PROD_W'(sum_g_q) * PROD_W'(bb3_pkg::recip(cnt_q));
      prod_b_q <= PROD_W'(sum_b_q) * PROD_W'(bb3_pkg::recip(cnt_q));
    end
  end

  assign out_o.red_out   = prod_r_q[bb3_pkg::RECIP_SH +: CH_W];
  assign out_o.green_out = prod_g_q[bb3_pkg::RECIP_SH +: CH_W];
  assign out_o.blue_out  = prod_b_q[bb3_pkg::RECIP_SH +: CH_W];

endmodule

/* sv/box_blur_3x3_rgb_core.sv */
// A read steps the core through setup, gather, drain, divide and the done_o
// cycle; the gather reads the n = 1..9 pixels of the clamped window through
// the one read port of the frame store, one pixel a cycle. A read holds busy through
// done_o; a write completes at its accepting edge and the next item may follow at once.
// Results are strobed for one cycle; the receiver cannot stall. Reset clears
// the controller and sets both sizes to 256; the frame store is not cleared.
// Top level of the box blur core; instantiates bb3_ctrl and bb3_datapath.

module box_blur_3x3_rgb_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bb3_pkg::in_item_t             in_i,
  output logic                          done_o,
  output bb3_pkg::out_item_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data_i
);

  bb3_pkg::dp_cmd_t    cmd;
  bb3_pkg::dp_status_t status;

  // Sequencer
  bb3_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (in_i.operation),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // Frame store and arithmetic
  bb3_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_o      (out_o)
  );

endmodule

/* sv/bb3_checker.sv */
// Port-level checks for the box blur core, with the bind that attaches them.
// Depends on bb3_pkg and box_blur_3x3_rgb_core.

module bb3_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input bb3_pkg::in_item_t in_i,
  input logic              done_o
);

  // A result only shows while the block is working on a read
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("done_o without busy");

  // A result strobe lasts one cycle and frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle or block stays busy");

  // A write transfer completes at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.operation == bb3_pkg::OP_WRITE)) |=> !busy)
    else $error("write left the block busy");

  // A read transfer occupies the block and gives no immediate result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.operation == bb3_pkg::OP_READ)) |=> busy && !done_o)
    else $error("read did not occupy the block");

endmodule

bind box_blur_3x3_rgb_core bb3_checker u_bb3_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .in_i   (in_i),
  .done_o (done_o)
);

/* bench/tb.sv */
// Self-checking bench for box_blur_3x3_rgb_core: pixel writes and blurred reads
// are predicted by a frame model class; depends on bb3_pkg and the core RTL.

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 16;   // outlasts the longest read
  localparam int unsigned PHASE_ITEMS = 103;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned FRAME_SIZE  = bb3_pkg::MAX_WIDTH * bb3_pkg::MAX_HEIGHT;

  // Frame model: shadow frame store, size registers and expected blur results
  class blur_frame_model;
    bit [bb3_pkg::PIX_W-1:0]   pixels  [FRAME_SIZE];
    bit                        written [FRAME_SIZE];
    logic [bb3_pkg::CFG_W-1:0] width_reg;
    logic [bb3_pkg::CFG_W-1:0] height_reg;
    bb3_pkg::out_item_t        pending_means [$];
    int unsigned               faults;

    function new();
      width_reg  = bb3_pkg::CFG_SIZE_RESET;
      height_reg = bb3_pkg::CFG_SIZE_RESET;
      faults     = 0;
    endfunction

    // Zero counts as one, anything past the maximum saturates
    function int unsigned size_in_use(logic [bb3_pkg::CFG_W-1:0] v, int unsigned max);
      if (v == 0) return 1;
      if (v > max) return max;
      return v;
    endfunction

    function int unsigned cols_in_use();
      return size_in_use(width_reg, bb3_pkg::MAX_WIDTH);
    endfunction

    function int unsigned rows_in_use();
      return size_in_use(height_reg, bb3_pkg::MAX_HEIGHT);
    endfunction

    function void set_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                          logic [bb3_pkg::CFG_W-1:0] data);
      if (idx == bb3_pkg::REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == bb3_pkg::REG_IMAGE_HEIGHT) height_reg = data;
    endfunction

    // Clamped 3x3 window around a read position; position saturates first
    function void window(input int unsigned row, input int unsigned col,
                         output int unsigned r0, output int unsigned r1,
                         output int unsigned c0, output int unsigned c1);
      int unsigned h;
      int unsigned w;
      h = rows_in_use();
      w = cols_in_use();
      if (row >= h) row = h - 1;
      if (col >= w) col = w - 1;
      r0 = (row > 0) ? row - 1 : 0;
      c0 = (col > 0) ? col - 1 : 0;
      r1 = (row + 1 < h) ? row + 1 : h - 1;
      c1 = (col + 1 < w) ? col + 1 : w - 1;
    endfunction

    // Accepted input transfer: store a pixel or queue the expected mean
    function void note_transfer(bb3_pkg::in_item_t it);
      int unsigned        r0, r1, c0, c1, y, x, addr;
      int unsigned        sr, sg, sb, n;
      bb3_pkg::out_item_t mean;
      if (it.operation == bb3_pkg::OP_WRITE) begin
        if (it.row < rows_in_use() && it.col < cols_in_use()) begin
          addr          = it.row * bb3_pkg::MAX_WIDTH + it.col;
          pixels[addr]  = {it.red_in, it.green_in, it.blue_in};
          written[addr] = 1'b1;
        end
      end else begin
        window(it.row, it.col, r0, r1, c0, c1);
        sr = 0; sg = 0; sb = 0; n = 0;
        for (y = r0; y <= r1; y++) begin
          for (x = c0; x <= c1; x++) begin
            addr = y * bb3_pkg::MAX_WIDTH + x;
            sr += pixels[addr][23:16];
            sg += pixels[addr][15:8];
            sb += pixels[addr][7:0];
            n++;
          end
        end
        mean.red_out   = 8'(sr / n);
        mean.green_out = 8'(sg / n);
        mean.blue_out  = 8'(sb / n);
        pending_means.push_back(mean);
      end
    endfunction

    // Result transfer: compare against the oldest pending mean
    function void check_pixel(bb3_pkg::out_item_t got);
      bb3_pkg::out_item_t exp_px;
      if (pending_means.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result: r=%0d g=%0d b=%0d",
                   got.red_out, got.green_out, got.blue_out);
      end else begin
        exp_px = pending_means.pop_front();
        if (got.red_out !== exp_px.red_out || got.green_out !== exp_px.green_out ||
            got.blue_out !== exp_px.blue_out) begin
          faults++;
          if (faults <= 10)
            $display("blur mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     exp_px.red_out, exp_px.green_out, exp_px.blue_out,
                     got.red_out, got.green_out, got.blue_out);
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  bb3_pkg::in_item_t             in_item;
  logic                          done_o;
  bb3_pkg::out_item_t            out_o;
  logic                          cfg_we_i;
  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [bb3_pkg::CFG_W-1:0]     cfg_data_i;

  blur_frame_model           model;
  int unsigned               sent;
  int unsigned               idle_pct;
  int unsigned               cycle_cnt;
  logic [bb3_pkg::CFG_W-1:0] phase_w [NUM_PHASES];
  logic [bb3_pkg::CFG_W-1:0] phase_h [NUM_PHASES];

  box_blur_3x3_rgb_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_item),
    .done_o     (done_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side cannot be throttled; check every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) model.check_pixel(out_o);
  end

  // Channel value with the extremes favored
  function automatic logic [bb3_pkg::CH_W-1:0] chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return bb3_pkg::CH_W'($urandom);
    endcase
  endfunction

  function automatic bb3_pkg::in_item_t make_item(logic op, int unsigned row,
                                                  int unsigned col);
    bb3_pkg::in_item_t it;
    it.operation = op;
    it.row       = bb3_pkg::ROW_W'(row);
    it.col       = bb3_pkg::COL_W'(col);
    it.red_in    = chan();
    it.green_in  = chan();
    it.blue_in   = chan();
    return it;
  endfunction

  // Coordinate biased to edges, a hot band, and positions past the edge
  function automatic int unsigned pick_coord(int unsigned size);
    int unsigned band;
    band = (size < 12) ? size : 12;
    case ($urandom_range(7))
      0:       return 0;
      1:       return size - 1;
      2:       return (size < 256) ? $urandom_range(255, size) : 255;
      3:       return $urandom_range(size - 1);
      4:       return size - band + $urandom_range(band - 1);
      default: return $urandom_range(band - 1);
    endcase
  endfunction

  // One input transfer, after an optional random idle stretch
  task automatic send_item(bb3_pkg::in_item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (busy);
    model.note_transfer(it);
    sent++;
  endtask

  // Fill any unwritten pixel of the window (sometimes rewrite one), then read
  task automatic blurred_read(int unsigned row, int unsigned col);
    int unsigned r0, r1, c0, c1, y, x;
    model.window(row, col, r0, r1, c0, c1);
    for (y = r0; y <= r1; y++) begin
      for (x = c0; x <= c1; x++) begin
        if (!model.written[y * bb3_pkg::MAX_WIDTH + x] || $urandom_range(15) == 0)
          send_item(make_item(bb3_pkg::OP_WRITE, y, x));
      end
    end
    send_item(make_item(bb3_pkg::OP_READ, row, col));
  endtask

  // Wait for all pending reads, then for the core to go quiet
  task automatic settle();
    while (model.pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Both size registers, back to back
  task automatic configure(logic [bb3_pkg::CFG_W-1:0] w, logic [bb3_pkg::CFG_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bb3_pkg::REG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    model.set_reg(bb3_pkg::REG_IMAGE_WIDTH, w);
    cfg_idx_i  <= bb3_pkg::REG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    model.set_reg(bb3_pkg::REG_IMAGE_HEIGHT, h);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int unsigned       ph, goal, sel, row, col, y, x;
    bb3_pkg::in_item_t it;

    model      = new();
    sent       = 0;
    idle_pct   = 0;
    start      <= 1'b0;
    in_item    <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= bb3_pkg::REG_IMAGE_WIDTH;
    cfg_data_i <= '0;
    rst_ni     <= 1'b0;

    // Sizes per phase: zero, over-range and one-wide cases included
    phase_w = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd1, 9'd256, 9'd3, 9'd0, 9'd17, 9'd256};
    phase_h = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd256, 9'd1, 9'd3, 9'd0, 9'd9, 9'd256};
    phase_w[7] = bb3_pkg::CFG_W'($urandom_range(40, 2));
    phase_h[7] = bb3_pkg::CFG_W'($urandom_range(40, 2));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Far corner under the reset sizes
    for (y = 254; y <= 255; y++) begin
      for (x = 254; x <= 255; x++) begin
        it          = make_item(bb3_pkg::OP_WRITE, y, x);
        it.red_in   = (x == 255) ? 8'hFF : 8'h00;
        it.green_in = (y == 255) ? 8'hFF : 8'h00;
        it.blue_in  = 8'hFF;
        send_item(it);
      end
    end
    send_item(make_item(bb3_pkg::OP_READ, 255, 255));
    start <= 1'b0;

    // Small 4x3 image: full fill, ignored writes, saturated reads
    settle();
    configure(9'd4, 9'd3);
    for (y = 0; y < 3; y++) begin
      for (x = 0; x < 4; x++) begin
        it          = make_item(bb3_pkg::OP_WRITE, y, x);
        it.red_in   = 8'((y * 4 + x) * 23);
        it.green_in = ~it.red_in;
        it.blue_in  = (x == 3) ? 8'hFF : ((x == 0) ? 8'h00 : it.blue_in);
        send_item(it);
      end
    end
    send_item(make_item(bb3_pkg::OP_WRITE, 3, 0));
    send_item(make_item(bb3_pkg::OP_WRITE, 0, 4));
    send_item(make_item(bb3_pkg::OP_READ, 0, 0));
    send_item(make_item(bb3_pkg::OP_READ, 1, 1));
    send_item(make_item(bb3_pkg::OP_READ, 2, 3));
    send_item(make_item(bb3_pkg::OP_READ, 0, 3));
    send_item(make_item(bb3_pkg::OP_READ, 255, 255));
    send_item(make_item(bb3_pkg::OP_READ, 1, 200));
    start <= 1'b0;

    // Random phases: mostly filled-window reads, some stray and ignored writes
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      configure(phase_w[ph], phase_h[ph]);
      case (ph % 4)
        1:       idle_pct = 64;
        3:       idle_pct = 38;
        default: idle_pct = 0;
      endcase
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        sel = $urandom_range(99);
        row = pick_coord(model.rows_in_use());
        col = pick_coord(model.cols_in_use());
        if (sel < 75)
          blurred_read(row, col);
        else if (sel < 90)
          send_item(make_item(bb3_pkg::OP_WRITE, row, col));
        else
          send_item(make_item(bb3_pkg::OP_WRITE, $urandom_range(255), $urandom_range(255)));
      end
      start <= 1'b0;
    end

    settle();
    if (model.faults == 0 && model.pending_means.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
